/* design/fpq_pkg.sv */
// Shared types and constants of the fixed-point quantizer with statistics.
// Used by the rounding unit, the shared divider and the top level; depends on nothing.

package fpq_pkg;

  // Counter width parameter of the statistics: counts are COUNT_BITS+1 bits wide.
  localparam int unsigned COUNT_BITS = 20;
  localparam int unsigned CNT_W      = COUNT_BITS + 1;
  localparam int unsigned ESUM_W     = COUNT_BITS + 17;

  localparam int unsigned DIV_W  = 32;
  localparam int unsigned QUOT_W = 17;

  localparam logic [QUOT_W-1:0] ONE_Q16  = QUOT_W'(17'h10000);
  localparam logic [4:0]        FB_MAX   = 5'd16;
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [ESUM_W-1:0] ESUM_MAX = {ESUM_W{1'b1}};

  // Configuration register indexes.
  localparam logic CFG_INT_BITS  = 1'b0;
  localparam logic CFG_FRAC_BITS = 1'b1;

  // Result of quantizing one sample.
  typedef struct packed {
    logic [31:0] rounded;
    logic        sat;
    logic        changed;
    logic [31:0] diff;
    logic [31:0] mag;
  } rnd_t;

  // Request to the shared divider: quotient of {hi, lo} by divisor, capped at one.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] hi;
    logic [15:0]      lo;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

/* design/fpq_round.sv */
// Saturation and rounding of one Q15.16 sample, with error magnitude and sample magnitude.
// Depends on fpq_pkg.

module fpq_round import fpq_pkg::*; (
  input  logic signed [31:0] sample_i,
  input  logic [3:0]         int_bits_i,
  input  logic [4:0]         frac_bits_i,  // already limited to sixteen
  output rnd_t               rnd_o
);

  logic signed [33:0] s34;
  logic signed [33:0] bound;
  logic signed [33:0] neg_bound;
  logic               sat_hi;
  logic               sat_lo;
  logic               s_neg;
  logic        [31:0] s_abs;
  logic        [48:0] sm_sh;
  logic        [48:0] nm_pos;
  logic        [49:0] nm_neg;
  logic        [32:0] qmag;
  logic        [32:0] rmag;
  logic        [31:0] rmag_c;
  logic        [31:0] r_rnd;
  logic        [31:0] r_out;
  logic               r_ge;
  logic        [31:0] diff;

  assign s34       = {{2{sample_i[31]}}, sample_i};
  assign bound     = $signed(34'(1) << (6'(int_bits_i) + 6'd16));
  assign neg_bound = -bound;
  assign sat_hi    = s34 > bound;
  assign sat_lo    = s34 < neg_bound;

  assign s_neg = sample_i[31];
  assign s_abs = s_neg ? 32'(-sample_i) : 32'(sample_i);

  // Work on the magnitude: scale up, add one half for a positive sample or take one half
  // away for a negative one, then truncate. A negative sample whose scaled magnitude does
  // not exceed one half rounds to zero.
  assign sm_sh  = {17'd0, s_abs} << frac_bits_i;
  assign nm_pos = sm_sh + 49'd32768;
  assign nm_neg = {1'b0, sm_sh} - 50'd32768;
  assign qmag   = s_neg ? (nm_neg[49] ? 33'd0 : nm_neg[48:16]) : nm_pos[48:16];
  assign rmag   = qmag << (5'd16 - frac_bits_i);

  // Only a positive sample can round up past the largest Q15.16 value.
  assign rmag_c = (rmag[32:31] != 2'b00) ? 32'h7FFF_FFFF : rmag[31:0];
  assign r_rnd  = s_neg ? -rmag_c : rmag_c;
  assign r_out  = sat_hi ? bound[31:0] : (sat_lo ? neg_bound[31:0] : r_rnd);

  // The rounded value never takes the opposite sign, so the error is a magnitude difference.
  assign r_ge = rmag_c >= s_abs;
  assign diff = r_ge ? rmag_c - s_abs : s_abs - rmag_c;

  always_comb begin
    rnd_o.rounded = r_out;
    rnd_o.sat     = sat_hi | sat_lo;
    rnd_o.changed = !(sat_hi | sat_lo) && (rmag_c != s_abs);
    rnd_o.diff    = diff;
    rnd_o.mag     = s_abs;
  end

endmodule

/* design/fpq_div.sv */
// Shared restoring divider giving a Q1.16 quotient capped at one, one bit per cycle.
// Depends on fpq_pkg.

module fpq_div import fpq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [15:0]       lo_q, lo_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    trial_sub;
  logic              ge;

  assign trial     = {rem_q, lo_q[15]};
  assign trial_sub = trial - {1'b0, div_q};
  assign ge        = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    if (req_i.start) begin
      // A high part not below the divisor means a quotient of one or more.
      if (req_i.hi >= req_i.divisor) begin
        quot_d = ONE_Q16;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        rem_d  = req_i.hi;
        lo_d   = req_i.lo;
        div_d  = req_i.divisor;
        quot_d = '0;
        cnt_d  = 4'd15;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d  = ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
      lo_d   = {lo_q[14:0], 1'b0};
      quot_d = {quot_q[QUOT_W-2:0], ge};
      cnt_d  = cnt_q - 4'd1;
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

/* design/fixed_point_quantizer_with_stats_core.sv */
// Top level of the fixed-point quantizer with tensor statistics: sequencer and counters.
// Depends on fpq_pkg, fpq_round and fpq_div.
//
// Use: samples of one tensor arrive on the s_axis channel as signed Q15.16 in tdata,
// the final sample of a tensor marked by tlast. Each accepted item yields one result
// item on m_axis: the saturated or rounded sample, a saturation flag, and on the last
// sample the mean relative rounding error and the running overflow-rate total.
// The user must write int_bits and frac_bits through the cfg port only while the block is
// idle; the block itself does not enforce this. A saturated or unchanged sample passes
// from the idle state through the quantize and accumulate states to the output state,
// where it is loaded into the output register. A changed sample also needs one pass of
// the shared 16-step divider in the error state, shortened when the quotient caps at
// one. A last sample adds two more divider passes (mean error and overflow fraction). The
// block takes one item at a time; s_axis_tready is high only while the sequencer is idle.
// A held result does not stop the next item from being accepted; the sequencer only
// waits at the end of that item until the output register is free.
// Reset clears the statistics and the running total, restores int_bits to 7 and
// frac_bits to 8, and leaves the output channel empty.

module fixed_point_quantizer_with_stats_core import fpq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // [31:0] rounded, [48:32] avg_rel_error,
                                      // [80:49] overflow_rate_sum, [87:81] zero
  output logic [1:0]  m_axis_tuser    // [0] saturated, [1] stats_valid
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_QUANT = 7'b0000010,
    ST_ERR   = 7'b0000100,
    ST_ACC   = 7'b0001000,
    ST_AVG   = 7'b0010000,
    ST_OVF   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [3:0]        int_bits_q;
  logic [4:0]        frac_bits_q;
  logic [4:0]        frac_eff;

  logic [31:0]       sample_q;
  logic              last_q;
  rnd_t              rnd;
  logic [31:0]       rounded_q;
  logic              sat_q;
  logic [31:0]       diff_q;
  logic [31:0]       mag_q;
  logic              div_go_q;
  logic [QUOT_W-1:0] err_q;
  logic [QUOT_W-1:0] avg_q;

  logic [CNT_W-1:0]  elem_q, elem_d;
  logic [CNT_W-1:0]  ovf_q, ovf_d;
  logic [ESUM_W-1:0] esum_q, esum_d;
  logic [31:0]       total_q, total_d;
  logic [ESUM_W:0]   esum_add;
  logic [32:0]       total_add;
  logic [ESUM_W-1:0] esum_new;
  logic [CNT_W-1:0]  elem_new;
  logic [CNT_W-1:0]  ovf_new;

  logic              m_valid_q, m_valid_d;
  logic [87:0]       m_data_q;
  logic [1:0]        m_user_q;
  logic              out_load;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign frac_eff = (frac_bits_q > FB_MAX) ? FB_MAX : frac_bits_q;

  fpq_round u_round (
    .sample_i    (sample_q),
    .int_bits_i  (int_bits_q),
    .frac_bits_i (frac_eff),
    .rnd_o       (rnd)
  );

  fpq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Counter updates for the current sample, all saturating.
  assign esum_add  = {1'b0, esum_q} + (ESUM_W + 1)'(err_q);
  assign esum_new  = (esum_add > {1'b0, ESUM_MAX}) ? ESUM_MAX : esum_add[ESUM_W-1:0];
  assign elem_new  = (elem_q < CNT_MAX) ? elem_q + CNT_W'(1) : elem_q;
  assign ovf_new   = (sat_q && ovf_q < CNT_MAX) ? ovf_q + CNT_W'(1) : ovf_q;
  assign total_add = {1'b0, total_q} + 33'(div_rsp.quot);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    div_req = '0;
    unique case (state_q)
      ST_ERR: begin
        // The rounding result is registered first, so the divider starts in the cycle after the quantize state.
        div_req.start   = div_go_q;
        div_req.hi      = diff_q;
        div_req.divisor = mag_q;
      end
      ST_ACC: begin
        // Mean error: the sum split into a high part and sixteen low bits.
        div_req.start   = last_q;
        div_req.hi      = DIV_W'(esum_new[ESUM_W-1:16]);
        div_req.lo      = esum_new[15:0];
        div_req.divisor = DIV_W'(elem_new);
      end
      ST_AVG: begin
        div_req.start   = div_rsp.done;
        div_req.hi      = DIV_W'(ovf_q);
        div_req.divisor = DIV_W'(elem_q);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    elem_d  = elem_q;
    ovf_d   = ovf_q;
    esum_d  = esum_q;
    total_d = total_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_QUANT;
      end
      ST_QUANT: begin
        state_d = rnd.changed ? ST_ERR : ST_ACC;
      end
      ST_ERR: begin
        if (div_rsp.done) state_d = ST_ACC;
      end
      ST_ACC: begin
        elem_d  = elem_new;
        ovf_d   = ovf_new;
        esum_d  = esum_new;
        state_d = last_q ? ST_AVG : ST_OUT;
      end
      ST_AVG: begin
        if (div_rsp.done) state_d = ST_OVF;
      end
      ST_OVF: begin
        if (div_rsp.done) begin
          total_d = total_add[32] ? 32'hFFFFFFFF : total_add[31:0];
          elem_d  = '0;
          ovf_d   = '0;
          esum_d  = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      int_bits_q  <= 4'd7;
      frac_bits_q <= 5'd8;
      elem_q      <= '0;
      ovf_q       <= '0;
      esum_q      <= '0;
      total_q     <= '0;
      m_valid_q   <= 1'b0;
      div_go_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      elem_q    <= elem_d;
      ovf_q     <= ovf_d;
      esum_q    <= esum_d;
      total_q   <= total_d;
      m_valid_q <= m_valid_d;
      div_go_q  <= (state_q == ST_QUANT) && rnd.changed;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_INT_BITS) int_bits_q <= cfg_wdata_i[3:0];
        if (cfg_idx_i == CFG_FRAC_BITS) frac_bits_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample_q <= s_axis_tdata;
      last_q   <= s_axis_tlast;
    end
    if (state_q == ST_QUANT) begin
      rounded_q <= rnd.rounded;
      sat_q     <= rnd.sat;
      diff_q    <= rnd.diff;
      mag_q     <= rnd.mag;
      err_q     <= '0;
    end
    if (state_q == ST_ERR && div_rsp.done) err_q <= div_rsp.quot;
    if (state_q == ST_AVG && div_rsp.done) avg_q <= div_rsp.quot;
    if (out_load) begin
      m_user_q <= {last_q, sat_q};
      if (last_q) begin
        m_data_q <= {7'd0, total_q, avg_q, rounded_q};
      end else begin
        m_data_q <= {56'd0, rounded_q};
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

/* design/fpq_checker.sv */
// Port-level checks of the quantizer over time, bound to the top level.
// Depends on the top level's ports only.

module fpq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled result item keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again while an item is in work");

  // Statistics fields stay zero on items that do not close a tensor.
  a_stats_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[87:32] == 56'd0)
    else $error("statistics present on an item that is not last");

  // The mean error never exceeds one.
  a_avg_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[48:32] <= 17'h10000)
    else $error("mean relative error above one");

endmodule

bind fixed_point_quantizer_with_stats_core fpq_checker u_fpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* bench/quant_result_monitor.sv */
// Watches the sample and result channels of the fixed-point quantizer, predicts each
// result from its own copy of the statistics and configuration, and compares them.
// Depends on fpq_pkg for the register indexes and the counter width.
`timescale 1ns / 1ps

module quant_result_monitor import fpq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,   // [31:0] sample
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [87:0] m_tdata_i,   // [31:0] rounded, [48:32] avg_rel_error,
                                   // [80:49] overflow_rate_sum, [87:81] zero
  input  logic [1:0]  m_tuser_i,   // [0] saturated, [1] stats_valid
  output int          mismatches_o,
  output int          pending_o
);

  localparam longint CountCap   = (longint'(1) << (COUNT_BITS + 1)) - 1;
  localparam longint ErrSumCap  = (longint'(1) << (COUNT_BITS + 17)) - 1;
  localparam longint OneQ16     = 65536;
  localparam longint TotalCap   = 64'h0000_0000_FFFF_FFFF;
  localparam int     MaxReports = 60;

  typedef struct {
    logic [31:0] rounded;
    logic        sat;
    logic        stats;
    logic [16:0] avg_err;
    logic [31:0] rate_total;
  } quant_res_t;

  logic [3:0] range_exp;
  logic [4:0] keep_bits;
  longint     elem_cnt;
  longint     sat_cnt;
  longint     err_sum;
  longint     rate_total;
  quant_res_t want_q[$];
  int         n_bad = 0;

  assign mismatches_o = n_bad;

  // Quantizes one sample and folds it into the tensor statistics.
  function automatic quant_res_t quantize_sample(input logic [31:0] raw, input logic lst);
    quant_res_t res;
    longint     s, bnd, n, q, r, diff, mag, rel, cnt, avg, frac, tot;
    int         fb;
    res = '{rounded: '0, sat: 1'b0, stats: 1'b0, avg_err: '0, rate_total: '0};
    s   = longint'($signed(raw));
    fb  = (keep_bits > 5'd16) ? 16 : int'(keep_bits);
    bnd = longint'(1) << (int'(range_exp) + 16);
    if (s > bnd) begin
      r = bnd;
      res.sat = 1'b1;
    end else if (s < -bnd) begin
      r = -bnd;
      res.sat = 1'b1;
    end else begin
      // Adding a half and truncating towards zero rounds negative halves up.
      n = s * (longint'(1) << fb) + 32768;
      if (n >= 0) q = n >>> 16;
      else q = -((-n) >>> 16);
      r = q * (longint'(1) << (16 - fb));
      if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
      if (r != s) begin
        diff = (r > s) ? r - s : s - r;
        mag  = (s < 0) ? -s : s;
        rel  = (mag != 0) ? (diff << 16) / mag : OneQ16;
        if (rel > OneQ16) rel = OneQ16;
        err_sum = err_sum + rel;
        if (err_sum > ErrSumCap) err_sum = ErrSumCap;
      end
    end
    if (elem_cnt < CountCap) elem_cnt++;
    if (res.sat && sat_cnt < CountCap) sat_cnt++;
    res.rounded = r[31:0];
    if (lst) begin
      cnt  = (elem_cnt != 0) ? elem_cnt : 1;
      avg  = err_sum / cnt;
      frac = (sat_cnt << 16) / cnt;
      if (avg > OneQ16) avg = OneQ16;
      if (frac > OneQ16) frac = OneQ16;
      tot = rate_total + frac;
      if (tot > TotalCap) tot = TotalCap;
      rate_total     = tot;
      res.stats      = 1'b1;
      res.avg_err    = avg[16:0];
      res.rate_total = tot[31:0];
      elem_cnt = 0;
      sat_cnt  = 0;
      err_sum  = 0;
    end
    return res;
  endfunction

  task automatic cmp_field(input string what, input longint want, input longint got);
    if (want != got) begin
      n_bad++;
      if (n_bad <= MaxReports)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    quant_res_t want;
    if (!rst_ni) begin
      range_exp  = 4'd7;
      keep_bits  = 5'd8;
      elem_cnt   = 0;
      sat_cnt    = 0;
      err_sum    = 0;
      rate_total = 0;
      want_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INT_BITS:  range_exp = cfg_wdata_i[3:0];
          CFG_FRAC_BITS: keep_bits = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (want_q.size() == 0) begin
          n_bad++;
          if (n_bad <= MaxReports)
            $display("%0t: result with nothing expected, expected none, actual rounded %h",
                     $time, m_tdata_i[31:0]);
        end else begin
          want = want_q.pop_front();
          cmp_field("rounded", want.rounded, m_tdata_i[31:0]);
          cmp_field("saturated", want.sat, m_tuser_i[0]);
          cmp_field("stats_valid", want.stats, m_tuser_i[1]);
          cmp_field("avg_rel_error", want.avg_err, m_tdata_i[48:32]);
          cmp_field("overflow_rate_sum", want.rate_total, m_tdata_i[80:49]);
          cmp_field("tdata padding", 0, m_tdata_i[87:81]);
        end
      end
      if (s_tvalid_i && s_tready_i) want_q.push_back(quantize_sample(s_tdata_i, s_tlast_i));
      pending_o <= want_q.size();
    end
  end

endmodule

/* bench/tb_fixed_point_quantizer_with_stats_core.sv */
// Top of the quantizer testbench: clock, reset, sample and register stimulus, verdict.
// Depends on fpq_pkg, the quantizer core and quant_result_monitor.
`timescale 1ns / 1ps

module tb_fixed_point_quantizer_with_stats_core;
  import fpq_pkg::*;

  localparam int RandomItems = 650;
  localparam int CalmTail    = 100;
  localparam int QuietLimit  = 2000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = CFG_INT_BITS;
  logic [4:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int mismatches;
  int pending;
  int n_items    = 0;
  int n_tensors  = 0;
  int n_settings = 0;
  int quiet      = 0;
  int rx_hold    = 0;
  bit idle_en    = 1'b1;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  fixed_point_quantizer_with_stats_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  quant_result_monitor u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Result side: random stalls on m_axis_tready, which begin only while idle_en is set.
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rx_hold       <= $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, QuietLimit);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(input logic [31:0] smp, input logic lst);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    if (lst) n_tensors++;
  endtask

  // Registers change only once every result of the earlier items has been taken.
  task automatic configure(input int ib, input int fb);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_INT_BITS;
    cfg_wdata_i <= 5'(ib);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_FRAC_BITS;
    cfg_wdata_i <= 5'(fb);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_settings++;
  endtask

  // Samples aimed at the interesting regions of the current range and precision.
  function automatic logic [31:0] pick_sample(input int ib, input int fb);
    longint bnd, v, stp;
    int     efb;
    bnd = longint'(1) << (ib + 16);
    efb = (fb > 16) ? 16 : fb;
    case ($urandom_range(0, 5))
      0: v = longint'($signed($urandom()));
      1: v = longint'($urandom_range(0, 32'(bnd)));
      2: v = bnd + longint'($urandom_range(0, 4)) - 2;
      3: begin
        if (efb < 16) begin
          stp = longint'(1) << (16 - efb);
          v   = longint'($urandom_range(0, 4000)) * stp + stp / 2;
        end else begin
          v = longint'($urandom_range(0, 4095));
        end
      end
      4: v = longint'($urandom_range(0, 4095));
      default: v = longint'($urandom_range(0, 32'(bnd >> $urandom_range(0, 12))));
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v[31:0];
  endfunction

  initial begin
    int ib, fb, len;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: bound 2^7 and eight fraction bits.
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0080, 1'b0);   // exact half, rounds up
    send_item(32'hFFFF_FF80, 1'b0);   // negative exact half, rounds towards zero
    send_item(32'h0080_0000, 1'b0);   // exactly on the upper bound
    send_item(32'h0080_0001, 1'b0);
    send_item(32'hFF80_0000, 1'b0);   // exactly on the lower bound
    send_item(32'hFF7F_FFFF, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b1);
    // Widest range: nothing saturates, and rounding can run past the top.
    configure(15, 0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_8000, 1'b0);
    send_item(32'hFFFF_8000, 1'b0);
    send_item(32'h0001_8000, 1'b1);
    // Narrowest range, fraction count above sixteen.
    configure(0, 31);
    send_item(32'h0001_0000, 1'b0);
    send_item(32'h0001_0001, 1'b0);
    send_item(32'hFFFE_FFFF, 1'b0);
    send_item(32'h1234_5678, 1'b1);
    // Single-sample tensors.
    configure(3, 16);
    send_item(32'h0000_0001, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b1);

    while (n_items < 22 + RandomItems) begin
      if (n_items >= 22 + RandomItems - CalmTail) idle_en <= 1'b0;
      else idle_en <= ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: ib = 0;
        1: ib = 15;
        default: ib = $urandom_range(0, 15);
      endcase
      case ($urandom_range(0, 4))
        0: fb = 0;
        1: fb = 16;
        2: fb = $urandom_range(17, 31);
        default: fb = $urandom_range(0, 16);
      endcase
      configure(ib, fb);
      repeat ($urandom_range(1, 6)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) send_item(pick_sample(ib, fb), k == len - 1);
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (64) @(posedge clk_i);
    $display("Quantized %0d samples in %0d tensors over %0d range and precision settings,",
             n_items, n_tensors, n_settings + 1);
    $display("with random stalls on both channels and %0d mismatches.", mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/fpq_pkg.sv
design/fpq_round.sv
design/fpq_div.sv
design/fixed_point_quantizer_with_stats_core.sv
design/fpq_checker.sv
bench/quant_result_monitor.sv
bench/tb_fixed_point_quantizer_with_stats_core.sv
